[design/nms_pkg.sv]
// Shared types and constants for the non-maximum suppression engine.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
package nms_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int IOU_STAGES = 5;

   localparam logic [1:0] CSR_IOU_LIMIT = 2'd0;
   localparam logic [1:0] CSR_CONFIDENCE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_PER_CLASS_MODE = 2'd2;

   localparam logic [15:0] IOU_LIMIT_RESET = 16'd29491;
   localparam logic [15:0] CONFIDENCE_LIMIT_RESET = 16'd128;

   typedef struct packed {
      logic [15:0] left_edge;
      logic [15:0] top_edge;
      logic [15:0] right_edge;
      logic [15:0] bottom_edge;
      logic signed [15:0] score;
      logic [6:0] label;
      logic final_box;
   } req_type;

   typedef struct packed {
      logic [15:0] out_left;
      logic [15:0] out_top;
      logic [15:0] out_right;
      logic [15:0] out_bottom;
      logic signed [15:0] out_score;
      logic [6:0] out_label;
      logic kept;
      logic entry_valid;
      logic overflowed;
      logic end_of_run;
   } rsp_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
   } corners_type;

   typedef struct packed {
      corners_type corners;
      logic signed [15:0] score;
      logic [6:0] label;
   } stored_type;

   typedef struct packed {
      req_type box;
      logic store;
   } queue_entry_type;

   typedef struct packed {
      logic valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SUP_START,
      ST_SUP_I_RD,
      ST_SUP_I_WAIT,
      ST_SUP_J_RD,
      ST_SUP_J_WAIT,
      ST_SUP_CALC,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_EMPTY
   } back_state_type;

endpackage

[design/nms_front.sv]
// Front end: drops non-final boxes not above the confidence limit, queues the rest.
// Depends on nms_pkg.
`timescale 1ns / 1ps
module nms_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  nms_pkg::req_type         req_data,
   input  logic signed [15:0]       confidence_limit,
   input  logic                     pop,
   output nms_pkg::queue_head_type  head
);

   nms_pkg::queue_entry_type q_ff [2];
   nms_pkg::queue_entry_type q_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       qualifies, push, do_pop;

   assign busy = (cnt_ff == 2'd2);
   assign qualifies = (req_data.score > confidence_limit);
   assign push = start && !busy && (qualifies || req_data.final_box);
   assign do_pop = pop && (cnt_ff != 2'd0);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.entry = q_ff[rp_ff];

   always_comb begin
      q_in.box = req_data;
      q_in.store = qualifies;
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
   end

endmodule

[design/nms_iou.sv]
// Five-stage overlap test: intersection * 65536 > limit * union, without division.
// Depends on nms_pkg.
`timescale 1ns / 1ps
module nms_iou (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch,
   input  nms_pkg::corners_type  box_a,
   input  nms_pkg::corners_type  box_b,
   input  logic [15:0]           iou_limit,
   output logic                  done,
   output logic                  hit
);

   logic [nms_pkg::IOU_STAGES-1:0] vld_ff, vld_in;
   logic [15:0] wa_ff, ha_ff, wb_ff, hb_ff, wi_ff, hi_ff;
   logic [15:0] wa_in, ha_in, wb_in, hb_in, wi_in, hi_in;
   logic [15:0] il, it, ir, ib;
   logic [31:0] aa_ff, ab_ff, ai_ff, aa_in, ab_in, ai_in;
   logic [31:0] inter_ff, inter_in, inter2_ff;
   logic [32:0] uni_ff, uni_in;
   logic [31:0] plo_ff, plo_in;
   logic [32:0] phi_ff, phi_in;
   logic [48:0] prod;
   logic        hit_ff, hit_in;

   function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
      span = (hi > lo) ? hi - lo : 16'd0;
   endfunction

   always_comb begin
      il = (box_a.left > box_b.left) ? box_a.left : box_b.left;
      it = (box_a.top > box_b.top) ? box_a.top : box_b.top;
      ir = (box_a.right < box_b.right) ? box_a.right : box_b.right;
      ib = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
      wa_in = span(box_a.left, box_a.right);
      ha_in = span(box_a.top, box_a.bottom);
      wb_in = span(box_b.left, box_b.right);
      hb_in = span(box_b.top, box_b.bottom);
      wi_in = span(il, ir);
      hi_in = span(it, ib);
      aa_in = wa_ff * ha_ff;
      ab_in = wb_ff * hb_ff;
      ai_in = wi_ff * hi_ff;
      inter_in = ai_ff;
      if (inter_in > aa_ff) begin
         inter_in = aa_ff;
      end
      if (inter_in > ab_ff) begin
         inter_in = ab_ff;
      end
      uni_in = {1'b0, aa_ff} + {1'b0, ab_ff} - {1'b0, inter_in};
      plo_in = iou_limit * uni_ff[15:0];
      phi_in = iou_limit * uni_ff[32:16];
      prod = {phi_ff, 16'd0} + {17'd0, plo_ff};
      hit_in = ({1'b0, inter2_ff, 16'd0} > prod);
      vld_in = {vld_ff[nms_pkg::IOU_STAGES-2:0], launch};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      ha_ff <= ha_in;
      wb_ff <= wb_in;
      hb_ff <= hb_in;
      wi_ff <= wi_in;
      hi_ff <= hi_in;
      aa_ff <= aa_in;
      ab_ff <= ab_in;
      ai_ff <= ai_in;
      inter_ff <= inter_in;
      uni_ff <= uni_in;
      inter2_ff <= inter_ff;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      hit_ff <= hit_in;
   end

   assign done = vld_ff[nms_pkg::IOU_STAGES-1];
   assign hit = hit_ff;

endmodule

[design/nms_back.sv]
// Back end: sorted box store, greedy suppression sequencer and result output.
// Depends on nms_pkg and nms_iou.
`timescale 1ns / 1ps
module nms_back (
   input  logic                     clock,
   input  logic                     reset,
   input  nms_pkg::queue_head_type  head,
   output logic                     pop,
   input  logic [15:0]              iou_limit,
   input  logic                     per_class_mode,
   output logic                     rsp_strobe,
   output nms_pkg::rsp_type         rsp_data
);

   localparam logic [nms_pkg::CNT_W-1:0] ONE = nms_pkg::CNT_W'(1);
   localparam logic [nms_pkg::CNT_W-1:0] FULL = nms_pkg::CNT_W'(nms_pkg::MAX_BOXES);

   nms_pkg::back_state_type state_ff, state_in;
   nms_pkg::stored_type mem_ff [nms_pkg::MAX_BOXES];
   nms_pkg::stored_type rd_data_ff, box_i_ff, box_i_in, wr_data, new_entry;
   nms_pkg::queue_entry_type cur_ff, cur_in;
   nms_pkg::rsp_type rsp_ff, rsp_in;
   logic [nms_pkg::CNT_W-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [nms_pkg::CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [nms_pkg::MAX_BOXES-1:0] keep_ff, keep_in;
   logic [nms_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic ovf_ff, ovf_in, rsp_valid_ff, rsp_valid_in, we, launch, iou_done, iou_hit;

   nms_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .box_a     (box_i_ff.corners),
      .box_b     (rd_data_ff.corners),
      .iou_limit (iou_limit),
      .done      (iou_done),
      .hit       (iou_hit)
   );

   always_comb begin
      new_entry.corners.left = cur_ff.box.left_edge;
      new_entry.corners.top = cur_ff.box.top_edge;
      new_entry.corners.right = cur_ff.box.right_edge;
      new_entry.corners.bottom = cur_ff.box.bottom_edge;
      new_entry.score = cur_ff.box.score;
      new_entry.label = cur_ff.box.label;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nms_pkg::ST_IDLE: begin
            if (head.valid) begin
               if (head.entry.store && count_ff != FULL) begin
                  state_in = nms_pkg::ST_INS_RD;
               end else if (head.entry.box.final_box) begin
                  state_in = nms_pkg::ST_SUP_START;
               end
            end
         end
         nms_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = cur_ff.box.final_box ? nms_pkg::ST_SUP_START : nms_pkg::ST_IDLE;
            end else begin
               state_in = nms_pkg::ST_INS_CMP;
            end
         end
         nms_pkg::ST_INS_CMP: begin
            if (rd_data_ff.score > cur_ff.box.score) begin
               state_in = cur_ff.box.final_box ? nms_pkg::ST_SUP_START : nms_pkg::ST_IDLE;
            end else begin
               state_in = nms_pkg::ST_INS_RD;
            end
         end
         nms_pkg::ST_SUP_START: begin
            state_in = (count_ff == '0) ? nms_pkg::ST_EMIT_EMPTY : nms_pkg::ST_SUP_I_RD;
         end
         nms_pkg::ST_SUP_I_RD: begin
            if (i_ff + ONE >= count_ff) begin
               state_in = nms_pkg::ST_EMIT_RD;
            end else if (keep_ff[i_ff[nms_pkg::IDX_W-1:0]]) begin
               state_in = nms_pkg::ST_SUP_I_WAIT;
            end
         end
         nms_pkg::ST_SUP_I_WAIT: state_in = nms_pkg::ST_SUP_J_RD;
         nms_pkg::ST_SUP_J_RD: begin
            if (j_ff == count_ff) begin
               state_in = nms_pkg::ST_SUP_I_RD;
            end else if (keep_ff[j_ff[nms_pkg::IDX_W-1:0]]) begin
               state_in = nms_pkg::ST_SUP_J_WAIT;
            end
         end
         nms_pkg::ST_SUP_J_WAIT: begin
            if (per_class_mode && rd_data_ff.label != box_i_ff.label) begin
               state_in = nms_pkg::ST_SUP_J_RD;
            end else begin
               state_in = nms_pkg::ST_SUP_CALC;
            end
         end
         nms_pkg::ST_SUP_CALC: begin
            if (iou_done) begin
               state_in = nms_pkg::ST_SUP_J_RD;
            end
         end
         nms_pkg::ST_EMIT_RD: state_in = nms_pkg::ST_EMIT_OUT;
         nms_pkg::ST_EMIT_OUT: begin
            state_in = (idx_ff + ONE == count_ff) ? nms_pkg::ST_IDLE : nms_pkg::ST_EMIT_RD;
         end
         nms_pkg::ST_EMIT_EMPTY: state_in = nms_pkg::ST_IDLE;
         default: state_in = nms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      cur_in = cur_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      i_in = i_ff;
      j_in = j_ff;
      keep_in = keep_ff;
      box_i_in = box_i_ff;
      we = 1'b0;
      wr_addr = idx_ff[nms_pkg::IDX_W-1:0];
      wr_data = new_entry;
      rd_addr = idx_ff[nms_pkg::IDX_W-1:0];
      launch = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         nms_pkg::ST_IDLE: begin
            pop = head.valid;
            if (head.valid) begin
               cur_in = head.entry;
               idx_in = count_ff;
               if (head.entry.store && count_ff == FULL) begin
                  ovf_in = 1'b1;
               end
            end
         end
         nms_pkg::ST_INS_RD: begin
            rd_addr = idx_ff[nms_pkg::IDX_W-1:0] - 1'b1;
            if (idx_ff == '0) begin
               we = 1'b1;
               count_in = count_ff + ONE;
            end
         end
         nms_pkg::ST_INS_CMP: begin
            we = 1'b1;
            if (rd_data_ff.score > cur_ff.box.score) begin
               count_in = count_ff + ONE;
            end else begin
               wr_data = rd_data_ff;
               idx_in = idx_ff - ONE;
            end
         end
         nms_pkg::ST_SUP_START: begin
            keep_in = '1;
            i_in = '0;
         end
         nms_pkg::ST_SUP_I_RD: begin
            rd_addr = i_ff[nms_pkg::IDX_W-1:0];
            j_in = i_ff + ONE;
            if (i_ff + ONE >= count_ff) begin
               idx_in = '0;
            end else if (!keep_ff[i_ff[nms_pkg::IDX_W-1:0]]) begin
               i_in = i_ff + ONE;
            end
         end
         nms_pkg::ST_SUP_I_WAIT: box_i_in = rd_data_ff;
         nms_pkg::ST_SUP_J_RD: begin
            rd_addr = j_ff[nms_pkg::IDX_W-1:0];
            if (j_ff == count_ff) begin
               i_in = i_ff + ONE;
            end else if (!keep_ff[j_ff[nms_pkg::IDX_W-1:0]]) begin
               j_in = j_ff + ONE;
            end
         end
         nms_pkg::ST_SUP_J_WAIT: begin
            rd_addr = j_ff[nms_pkg::IDX_W-1:0];
            if (per_class_mode && rd_data_ff.label != box_i_ff.label) begin
               j_in = j_ff + ONE;
            end else begin
               launch = 1'b1;
            end
         end
         nms_pkg::ST_SUP_CALC: begin
            rd_addr = j_ff[nms_pkg::IDX_W-1:0];
            if (iou_done) begin
               j_in = j_ff + ONE;
               if (iou_hit) begin
                  keep_in[j_ff[nms_pkg::IDX_W-1:0]] = 1'b0;
               end
            end
         end
         nms_pkg::ST_EMIT_RD: rd_addr = idx_ff[nms_pkg::IDX_W-1:0];
         nms_pkg::ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.out_left = rd_data_ff.corners.left;
            rsp_in.out_top = rd_data_ff.corners.top;
            rsp_in.out_right = rd_data_ff.corners.right;
            rsp_in.out_bottom = rd_data_ff.corners.bottom;
            rsp_in.out_score = rd_data_ff.score;
            rsp_in.out_label = rd_data_ff.label;
            rsp_in.kept = keep_ff[idx_ff[nms_pkg::IDX_W-1:0]];
            rsp_in.entry_valid = 1'b1;
            rsp_in.overflowed = ovf_ff;
            rsp_in.end_of_run = (idx_ff + ONE == count_ff);
            idx_in = idx_ff + ONE;
            if (idx_ff + ONE == count_ff) begin
               count_in = '0;
               ovf_in = 1'b0;
            end
         end
         nms_pkg::ST_EMIT_EMPTY: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.overflowed = ovf_ff;
            rsp_in.end_of_run = 1'b1;
            ovf_in = 1'b0;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nms_pkg::ST_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      i_ff <= i_in;
      j_ff <= j_in;
      keep_ff <= keep_in;
      box_i_ff <= box_i_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL) else $error("box count beyond store capacity");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == nms_pkg::ST_EMIT_OUT
         || $past(state_ff) == nms_pkg::ST_EMIT_EMPTY))
      else $error("result beat outside emit phase");
   a_iou_wait: assert property (@(posedge clock) disable iff (reset)
      iou_done |-> state_ff == nms_pkg::ST_SUP_CALC)
      else $error("overlap result arrived while not waiting");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == nms_pkg::ST_IDLE) else $error("queue popped while busy");

endmodule

[design/non_max_suppression_engine.sv]
// Top level of the non-maximum suppression engine: register file, front and back.
// Depends on nms_pkg, nms_front and nms_back.
`timescale 1ns / 1ps
// A box is taken when start is high and busy is low; a two-beat queue lets the
// front take boxes while the store is still working. Inserting a box into the
// score-sorted store moves each stored box that ranks at or below it one place
// down, with a read and then a compare and write per box, before the new box lands.
// Every move goes through the single read port of the store. After the final
// box, each compared pair goes through a store read and the overlap unit,
// and output reads each stored box in turn. Results appear one beat per strobe
// and must be taken at once.
module non_max_suppression_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nms_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output nms_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   logic [15:0] iou_limit_ff, iou_limit_in;
   logic [15:0] conf_limit_ff, conf_limit_in;
   logic        per_class_ff, per_class_in;
   logic        pop;
   nms_pkg::queue_head_type head;

   assign csr_ready = 1'b1;

   always_comb begin
      iou_limit_in = iou_limit_ff;
      conf_limit_in = conf_limit_ff;
      per_class_in = per_class_ff;
      if (csr_valid) begin
         case (csr_index)
            nms_pkg::CSR_IOU_LIMIT: iou_limit_in = csr_data;
            nms_pkg::CSR_CONFIDENCE_LIMIT: conf_limit_in = csr_data;
            nms_pkg::CSR_PER_CLASS_MODE: per_class_in = csr_data[0];
            default: per_class_in = per_class_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iou_limit_ff <= nms_pkg::IOU_LIMIT_RESET;
         conf_limit_ff <= nms_pkg::CONFIDENCE_LIMIT_RESET;
         per_class_ff <= 1'b1;
      end else begin
         iou_limit_ff <= iou_limit_in;
         conf_limit_ff <= conf_limit_in;
         per_class_ff <= per_class_in;
      end
   end

   nms_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .confidence_limit (conf_limit_ff),
      .pop              (pop),
      .head             (head)
   );

   nms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .iou_limit      (iou_limit_ff),
      .per_class_mode (per_class_ff),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

endmodule

[dv/non_max_suppression_engine_test.sv]
// Testbench for the non-maximum suppression engine: box sets are fed in, a local
// greedy-suppression predictor builds the expected outputs, checked beat by beat.
// Depends on nms_pkg and the non_max_suppression_engine RTL only.
`timescale 1ns / 1ps
module non_max_suppression_engine_test;

   localparam int IDLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   nms_pkg::req_type req_data = '0;
   logic rsp_strobe;
   nms_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   non_max_suppression_engine u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor state.
   logic [15:0] iou_thr;
   logic signed [15:0] score_thr;
   logic class_only;
   nms_pkg::stored_type box_list[$];
   logic dropped_seen;

   nms_pkg::rsp_type pending_beats[$];
   int errors = 0;
   int boxes_sent = 0;
   int beats_seen = 0;
   int sets_done = 0;
   int idle_cycles = 0;

   function automatic logic [31:0] extent(logic [15:0] lo, logic [15:0] hi);
      return (hi > lo) ? 32'(hi - lo) : 32'd0;
   endfunction

   function automatic logic too_close(nms_pkg::corners_type a, nms_pkg::corners_type b);
      logic [15:0] il, it, ir, ib;
      logic [63:0] area_a, area_b, overlap, joint;
      il = (a.left > b.left) ? a.left : b.left;
      it = (a.top > b.top) ? a.top : b.top;
      ir = (a.right < b.right) ? a.right : b.right;
      ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
      area_a = 64'(extent(a.left, a.right)) * 64'(extent(a.top, a.bottom));
      area_b = 64'(extent(b.left, b.right)) * 64'(extent(b.top, b.bottom));
      overlap = 64'(extent(il, ir)) * 64'(extent(it, ib));
      if (overlap > area_a) overlap = area_a;
      if (overlap > area_b) overlap = area_b;
      joint = area_a + area_b - overlap;
      return (overlap << 16) > 64'(iou_thr) * joint;
   endfunction

   task automatic predict_box(nms_pkg::req_type b);
      nms_pkg::stored_type s;
      int pos;
      logic keep[$];
      nms_pkg::rsp_type r;
      if (b.score > score_thr) begin
         if (box_list.size() >= nms_pkg::MAX_BOXES) begin
            dropped_seen = 1'b1;
         end else begin
            s.corners = {b.left_edge, b.top_edge, b.right_edge, b.bottom_edge};
            s.score = b.score;
            s.label = b.label;
            pos = 0;
            while (pos < box_list.size() && box_list[pos].score > b.score) pos++;
            box_list.insert(pos, s);
         end
      end
      if (!b.final_box) return;
      if (box_list.size() == 0) begin
         r = '0;
         r.overflowed = dropped_seen;
         r.end_of_run = 1'b1;
         pending_beats.push_back(r);
      end else begin
         foreach (box_list[i]) keep.push_back(1'b1);
         foreach (box_list[i]) begin
            if (keep[i]) begin
               for (int j = i + 1; j < box_list.size(); j++) begin
                  if (keep[j] && !(class_only && box_list[i].label != box_list[j].label)
                      && too_close(box_list[i].corners, box_list[j].corners))
                     keep[j] = 1'b0;
               end
            end
         end
         foreach (box_list[i]) begin
            r.out_left = box_list[i].corners.left;
            r.out_top = box_list[i].corners.top;
            r.out_right = box_list[i].corners.right;
            r.out_bottom = box_list[i].corners.bottom;
            r.out_score = box_list[i].score;
            r.out_label = box_list[i].label;
            r.kept = keep[i];
            r.entry_valid = 1'b1;
            r.overflowed = dropped_seen;
            r.end_of_run = (i == box_list.size() - 1);
            pending_beats.push_back(r);
         end
      end
      box_list.delete();
      dropped_seen = 1'b0;
   endtask

   // Result checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_strobe) begin
            beats_seen <= beats_seen + 1;
            if (pending_beats.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               if (rsp_data !== pending_beats[0]) begin
                  $display("%0t: mismatch expected %p actual %p", $time,
                           pending_beats[0], rsp_data);
                  errors <= errors + 1;
               end
               if (rsp_data.end_of_run) sets_done <= sets_done + 1;
               void'(pending_beats.pop_front());
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_box(nms_pkg::req_type b);
      @(negedge clock);
      start <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      predict_box(b);
      boxes_sent++;
      if ($urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         nms_pkg::CSR_IOU_LIMIT: iou_thr = val;
         nms_pkg::CSR_CONFIDENCE_LIMIT: score_thr = val;
         nms_pkg::CSR_PER_CLASS_MODE: class_only = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic nms_pkg::req_type rand_box(logic last, int label_span);
      nms_pkg::req_type b;
      logic [15:0] x, y;
      x = 16'($urandom_range(0, 400));
      y = 16'($urandom_range(0, 400));
      b.left_edge = x;
      b.top_edge = y;
      b.right_edge = x + 16'($urandom_range(0, 300));
      b.bottom_edge = y + 16'($urandom_range(0, 300));
      if ($urandom_range(0, 9) == 0) begin
         b.left_edge = 16'($urandom);
         b.top_edge = 16'($urandom);
         b.right_edge = 16'($urandom);
         b.bottom_edge = 16'($urandom);
      end
      b.score = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, 40)) * 16'sd32;
      b.label = 7'($urandom_range(0, label_span));
      if ($urandom_range(0, 15) == 0) b.label = 7'($urandom);
      b.final_box = last;
      return b;
   endfunction

   // Directed rows: corners, score, label, final flag.
   nms_pkg::req_type directed_rows[] = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'sd0, 7'd0, 1'b1},
      '{16'd0, 16'd0, 16'd160, 16'd160, 16'sd256, 7'd3, 1'b0},
      '{16'd16, 16'd16, 16'd176, 16'd176, 16'sd200, 7'd3, 1'b0},
      '{16'd16, 16'd16, 16'd176, 16'd176, 16'sd200, 7'd4, 1'b0},
      '{16'd500, 16'd500, 16'd400, 16'd400, 16'sd300, 7'd3, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 7'd127, 1'b0},
      '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'sd129, 7'd127, 1'b0},
      '{16'd0, 16'd0, 16'd10, 16'd10, 16'sd128, 7'd1, 1'b0},
      '{16'd0, 16'd0, 16'd10, 16'd10, 16'sh8000, 7'd1, 1'b0},
      '{16'd0, 16'd0, 16'd160, 16'd160, 16'sd256, 7'd3, 1'b1},
      '{16'd1, 16'd2, 16'd3, 16'd4, 16'sd5, 7'd6, 1'b1}
   };

   initial begin
      nms_pkg::req_type b;
      int set_size;
      iou_thr = nms_pkg::IOU_LIMIT_RESET;
      score_thr = nms_pkg::CONFIDENCE_LIMIT_RESET;
      class_only = 1'b1;
      dropped_seen = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A lone score below threshold gives the empty-set beat, typed in here.
      pending_beats.push_back('{default: '0, end_of_run: 1'b1});
      b = directed_rows[10];
      @(negedge clock);
      start <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      boxes_sent++;
      drain();
      foreach (directed_rows[k]) send_box(directed_rows[k]);
      drain();

      // Overflow: one more qualifying box than the store holds.
      for (int k = 0; k <= nms_pkg::MAX_BOXES; k++) begin
         b = rand_box(k == nms_pkg::MAX_BOXES, 3);
         b.score = 16'sd1000;
         send_box(b);
      end
      drain();

      write_reg(nms_pkg::CSR_PER_CLASS_MODE, 16'd0);
      write_reg(nms_pkg::CSR_IOU_LIMIT, 16'd0);
      write_reg(nms_pkg::CSR_CONFIDENCE_LIMIT, 16'h8000);
      for (int k = 0; k < 6; k++) send_box(rand_box(k == 5, 3));
      drain();
      write_reg(nms_pkg::CSR_IOU_LIMIT, 16'hFFFF);
      write_reg(nms_pkg::CSR_CONFIDENCE_LIMIT, 16'h7FFF);
      write_reg(2'd3, 16'hFFFF);
      for (int k = 0; k < 3; k++) send_box(rand_box(k == 2, 3));
      drain();

      while (boxes_sent < 210) begin
         write_reg(nms_pkg::CSR_IOU_LIMIT, 16'($urandom_range(0, 65535)));
         write_reg(nms_pkg::CSR_CONFIDENCE_LIMIT,
                   16'($urandom_range(0, 3)) * 16'd128 - 16'd64);
         write_reg(nms_pkg::CSR_PER_CLASS_MODE, 16'($urandom_range(0, 1)));
         for (int s = 0; s < 4; s++) begin
            set_size = $urandom_range(1, 12);
            for (int k = 0; k < set_size; k++) send_box(rand_box(k == set_size - 1, 2));
         end
         drain();
      end

      $display("Sent %0d boxes in %0d sets, checked %0d result beats with varied limits.",
               boxes_sent, sets_done, beats_seen);
      if (errors == 0 && pending_beats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
